### design/fpm_pkg.sv
// fpm_pkg: shared types, constants and the fraction log table of the frame psnr meter
// depends on nothing; every other file of the block imports it
`timescale 1ns / 1ps
`default_nettype none

package fpm_pkg;

   // sizing
   localparam int MAX_PIXELS_LOG2 = 24;
   localparam int LOG_TABLE_BITS  = 8;
   localparam int SAMPLE_W        = 8;
   localparam int NUM_LANES       = 3;
   localparam int SQ_W            = 2 * SAMPLE_W;
   localparam int LANE_SUM_W      = SQ_W + 2;
   localparam int CNT_W           = MAX_PIXELS_LOG2;
   localparam int PEAK_W          = 18;
   localparam int SUM_W           = CNT_W + PEAK_W;
   localparam int EXP_W           = $clog2(SUM_W);
   localparam int FRAC_W          = 16;
   localparam int LOG_W           = EXP_W + FRAC_W;
   localparam int SCALE_W         = 18;
   localparam int PROD_W          = LOG_W + SCALE_W;
   localparam int ROUND_SHIFT     = 24;
   localparam int Q_W             = PROD_W + 1 - ROUND_SHIFT;
   localparam int PSNR_W          = 16;
   localparam int TABLE_DEPTH     = 1 << LOG_TABLE_BITS;

   // constants of the psnr formula
   localparam logic [PEAK_W-1:0]  PEAK_SQ_X3      = 18'd195075;
   localparam logic [SCALE_W-1:0] TEN_LOG10_2_Q16 = 18'd197283;
   localparam logic [PSNR_W-1:0]  CAP_Q8          = 16'd51200;
   localparam logic [CNT_W-1:0]   COUNT_MAX       = {CNT_W{1'b1}};

   // request and response payloads
   typedef struct packed {
      logic [SAMPLE_W-1:0] ref_ch0;
      logic [SAMPLE_W-1:0] ref_ch1;
      logic [SAMPLE_W-1:0] ref_ch2;
      logic [SAMPLE_W-1:0] cmp_ch0;
      logic [SAMPLE_W-1:0] cmp_ch1;
      logic [SAMPLE_W-1:0] cmp_ch2;
      logic                frame_end;
   } req_payload_type;

   typedef struct packed {
      logic [PSNR_W-1:0] psnr_db;
      logic              identical;
   } rsp_payload_type;

   // totals of a finished frame, handed from the accumulator to the sequencer
   typedef struct packed {
      logic             valid;
      logic [SUM_W-1:0] sse;
      logic [CNT_W-1:0] count;
   } frame_type;

   // log unit status
   typedef struct packed {
      logic             done;
      logic [LOG_W-1:0] value;
   } log_status_type;

   typedef logic [FRAC_W-1:0] log_table_type [TABLE_DEPTH];

   // log2(1 + i/depth) in q16, by repeated truncating squaring of a q30 mantissa
   function automatic log_table_type build_log_table();
      log_table_type    t;
      logic [63:0]      m;
      logic [FRAC_W-1:0] r;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         m = 64'(TABLE_DEPTH + i) << (30 - LOG_TABLE_BITS);
         r = '0;
         for (int k = 0; k < FRAC_W; k++) begin
            m = (m * m) >> 30;
            r = {r[FRAC_W-2:0], 1'b0};
            if (m >= 64'h0000_0000_8000_0000) begin
               r[0] = 1'b1;
               m    = m >> 1;
            end
         end
         t[i] = r;
      end
      return t;
   endfunction

   localparam log_table_type LOG_TABLE = build_log_table();

endpackage

`default_nettype wire

### design/fpm_lane.sv
// fpm_lane: one channel lane, absolute difference and its square, registered
// depends on fpm_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpm_lane
   import fpm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                load,
   input  wire logic [SAMPLE_W-1:0] ref_sample,
   input  wire logic [SAMPLE_W-1:0] cmp_sample,
   output logic      [SQ_W-1:0]     sq_ff
);

   logic [SAMPLE_W-1:0] diff;
   logic [SQ_W-1:0]     sq_in;

   // absolute difference and square
   always_comb begin
      diff  = (ref_sample > cmp_sample) ? (ref_sample - cmp_sample)
                                        : (cmp_sample - ref_sample);
      sq_in = SQ_W'(diff) * SQ_W'(diff);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sq_ff <= sq_in;
      end
   end

endmodule

`default_nettype wire

### design/fpm_accum.sv
// fpm_accum: merging stage, adds the lane squares into the frame error sum and counts pixels
// depends on fpm_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpm_accum
   import fpm_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire logic                           in_end,
   input  wire logic [NUM_LANES-1:0][SQ_W-1:0] lane_sq,
   output frame_type                           frame
);

   logic [SUM_W-1:0]      sum_ff, sum_in, sum_upd;
   logic [CNT_W-1:0]      count_ff, count_in, count_upd;
   logic [LANE_SUM_W-1:0] lane_total;

   // merge the lanes
   always_comb begin
      lane_total = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         lane_total = lane_total + LANE_SUM_W'(lane_sq[i]);
      end
   end

   // accumulate until the count saturates, clear after the frame end pixel
   always_comb begin
      if (count_ff != COUNT_MAX) begin
         sum_upd   = sum_ff + SUM_W'(lane_total);
         count_upd = count_ff + CNT_W'(1);
      end else begin
         sum_upd   = sum_ff;
         count_upd = count_ff;
      end
      sum_in   = sum_ff;
      count_in = count_ff;
      if (in_valid) begin
         if (in_end) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_upd;
            count_in = count_upd;
         end
      end
      frame.valid = in_valid & in_end;
      frame.sse   = sum_upd;
      frame.count = count_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

### design/fpm_log2.sv
// fpm_log2: base-2 log in q16, leading-one search one bit a cycle, then table lookup
// depends on fpm_pkg (LOG_TABLE)
`timescale 1ns / 1ps
`default_nettype none

module fpm_log2
   import fpm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] value,
   output log_status_type        status
);

   logic [SUM_W-1:0] x_ff, x_in;
   logic [EXP_W-1:0] exp_ff, exp_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             zero_ff, zero_in;

   // normalize: shift left until the top bit is set
   always_comb begin
      x_in    = x_ff;
      exp_in  = exp_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      zero_in = zero_ff;
      if (start) begin
         x_in    = value;
         exp_in  = EXP_W'(SUM_W - 1);
         busy_in = (value != '0);
         done_in = (value == '0);
         zero_in = (value == '0);
      end else if (busy_ff) begin
         if (x_ff[SUM_W-1]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            x_in   = {x_ff[SUM_W-2:0], 1'b0};
            exp_in = exp_ff - EXP_W'(1);
         end
      end
   end

   // exponent and fraction bits below the leading one
   always_comb begin
      status.done  = done_ff;
      status.value = zero_ff ? '0
                             : {exp_ff, LOG_TABLE[x_ff[SUM_W-2 -: LOG_TABLE_BITS]]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         zero_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         zero_ff <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      exp_ff <= exp_in;
   end

endmodule

`default_nettype wire

### design/frame_psnr_meter.sv
// frame_psnr_meter: top level, lanes, accumulator, log units, psnr sequencer, response register
// depends on fpm_pkg, fpm_lane, fpm_accum, fpm_log2
//
// Takes one pixel pair per cycle while a frame is streaming: three lanes square the
// channel differences and a merging stage adds them into the frame error sum. The
// request marked frame_end closes the frame. From the cycle after it, requests are
// stalled while the psnr is worked out. A frame with zero error skips the logs. The
// time taken otherwise is set by the two log units, whose leading-one search shifts
// one bit per cycle along the 42-bit sum. The finished result may also wait until
// the output register is free.
// The result sits in an output register, so the next frame streams in while it
// waits to be taken; a second frame end waits in the sequencer if it is still full.
`timescale 1ns / 1ps
`default_nettype none

module frame_psnr_meter
   import fpm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_LOG   = 3'd2;
   localparam logic [2:0] ST_SCALE = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic                           req_accept;
   logic                           s1_valid_ff, s1_valid_in;
   logic                           s1_end_ff, s1_end_in;
   logic [NUM_LANES-1:0][SAMPLE_W-1:0] ref_samples, cmp_samples;
   logic [NUM_LANES-1:0][SQ_W-1:0] lane_sq;
   frame_type                      frame;

   logic [2:0]             state_ff, state_in;
   logic [SUM_W-1:0]       sse_ff, sse_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   identical_ff, identical_in;
   logic [LOG_W-1:0]       d_ff, d_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic                   sse_zero;
   logic                   log_start;
   logic [SUM_W-1:0]       num_value;
   log_status_type         num_log, den_log;
   logic [PROD_W:0]        round_sum;
   logic [Q_W-1:0]         q_full;
   logic [PSNR_W-1:0]      psnr_val;

   logic                   rsp_free;
   logic                   rsp_load;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff;

   // request handshake: hold off while a frame end is in flight or being finished
   assign req_stall  = (state_ff != ST_IDLE) | (s1_valid_ff & s1_end_ff);
   assign req_accept = req_valid & ~req_stall;

   assign ref_samples = {req_data.ref_ch2, req_data.ref_ch1, req_data.ref_ch0};
   assign cmp_samples = {req_data.cmp_ch2, req_data.cmp_ch1, req_data.cmp_ch0};

   // channel lanes
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      fpm_lane u_lane (
         .clock      (clock),
         .load       (req_accept),
         .ref_sample (ref_samples[g]),
         .cmp_sample (cmp_samples[g]),
         .sq_ff      (lane_sq[g])
      );
   end

   assign s1_valid_in = req_accept;
   assign s1_end_in   = req_accept ? req_data.frame_end : s1_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_end_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_end_ff   <= s1_end_in;
      end
   end

   // merging stage
   fpm_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .in_end   (s1_end_ff),
      .lane_sq  (lane_sq),
      .frame    (frame)
   );

   // log units for numerator and error sum
   assign sse_zero  = (sse_ff == '0);
   assign log_start = (state_ff == ST_MUL) & ~sse_zero;
   assign num_value = SUM_W'(count_ff) * SUM_W'(PEAK_SQ_X3);

   fpm_log2 u_num_log (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .value  (num_value),
      .status (num_log)
   );

   fpm_log2 u_den_log (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .value  (sse_ff),
      .status (den_log)
   );

   // rounding and cap of the scaled log difference
   always_comb begin
      round_sum = (PROD_W + 1)'(prod_ff) + ((PROD_W + 1)'(1) << (ROUND_SHIFT - 1));
      q_full    = round_sum[PROD_W:ROUND_SHIFT];
      if (identical_ff) begin
         psnr_val = CAP_Q8;
      end else if (q_full > Q_W'(CAP_Q8)) begin
         psnr_val = CAP_Q8;
      end else begin
         psnr_val = q_full[PSNR_W-1:0];
      end
   end

   assign rsp_free = ~rsp_valid_ff | ~rsp_stall;

   // psnr sequencer
   always_comb begin
      state_in     = state_ff;
      sse_in       = sse_ff;
      count_in     = count_ff;
      identical_in = identical_ff;
      d_in         = d_ff;
      prod_in      = prod_ff;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (frame.valid) begin
               sse_in   = frame.sse;
               count_in = frame.count;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            identical_in = sse_zero;
            state_in     = sse_zero ? ST_OUT : ST_LOG;
         end
         ST_LOG: begin
            if (num_log.done & den_log.done) begin
               d_in     = (num_log.value > den_log.value) ? (num_log.value - den_log.value)
                                                          : '0;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            prod_in  = PROD_W'(d_ff) * PROD_W'(TEN_LOG10_2_Q16);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      sse_ff       <= sse_in;
      count_ff     <= count_in;
      identical_ff <= identical_in;
      d_ff         <= d_in;
      prod_ff      <= prod_in;
   end

   // response register
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.psnr_db   <= psnr_val;
         rsp_data_ff.identical <= identical_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### design/fpm_checker.sv
// fpm_checker: port-level assertions of the frame psnr meter, bound to the top level
// depends on fpm_pkg and frame_psnr_meter
`timescale 1ns / 1ps
`default_nettype none

module fpm_checker
   import fpm_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_stall,
   input wire req_payload_type req_data,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire rsp_payload_type rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // a frame end request stalls the next one
   a_end_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.frame_end |=> req_stall)
      else $error("request accepted right after frame end");

   // identical frames report the cap
   a_identical_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.identical |-> rsp_data.psnr_db == CAP_Q8)
      else $error("identical frame without capped psnr");

   // psnr never above the cap
   a_psnr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.psnr_db <= CAP_Q8)
      else $error("psnr above cap");

endmodule

bind frame_psnr_meter fpm_checker u_fpm_checker (.*);

`default_nettype wire
